### hw/rtl/touch_stick_to_dpad_keys_unit_assert.svh
// Assertion macros for the touch stick to direction key unit.
// Define NO_ASSERTIONS to compile every check away.
`ifndef TOUCH_STICK_TO_DPAD_KEYS_UNIT_ASSERT_SVH
`define TOUCH_STICK_TO_DPAD_KEYS_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication: cons must hold whenever ante holds.
`define TSDK_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define TSDK_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define TSDK_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define TSDK_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### hw/rtl/tsdk_pkg.sv
package tsdk_pkg;

	localparam int AXIS_BITS_DEFAULT = 16;
	localparam int TIME_BITS_DEFAULT = 32;

	localparam int DZ_W    = 15;
	localparam int WIN_W   = 16;
	localparam int GAIN_W  = 16;
	localparam int DELTA_W = 16;
	localparam int REF_X_W = 18;
	localparam int XD_W    = 20;
	localparam int AIM_W   = 24;
	localparam int ACT_W   = 2;

	localparam logic signed [AIM_W-1:0] AIM_MAX = 24'sd8388607;
	localparam logic signed [AIM_W-1:0] AIM_MIN = -24'sd8388607;

	// APB register map
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_DEAD_ZONE   = 2'd0;
	localparam reg_idx_t REG_CARVE_WIN   = 2'd1;
	localparam reg_idx_t REG_AIM_GAIN    = 2'd2;

	localparam logic [DZ_W-1:0]   DEAD_ZONE_RST = 15'd3276;
	localparam logic [WIN_W-1:0]  CARVE_WIN_RST = 16'd300;
	localparam logic [GAIN_W-1:0] AIM_GAIN_RST  = 16'd1966;

	// Key flag bits
	localparam int KEY_LEFT  = 0;
	localparam int KEY_RIGHT = 1;
	localparam int KEY_UP    = 2;
	localparam int KEY_DOWN  = 3;
	localparam int KEY_CARVE = 4;
	localparam int KEY_N     = 5;

	// Menu axis lock bits
	localparam int LOCK_H = 0;
	localparam int LOCK_V = 1;

	typedef logic [ACT_W-1:0] act_code_t;
	localparam act_code_t ACT_NONE    = 2'd0;
	localparam act_code_t ACT_PRESS   = 2'd1;
	localparam act_code_t ACT_RELEASE = 2'd2;
	localparam act_code_t ACT_BOTH    = 2'd3;

	localparam act_code_t CARVE_NONE    = 2'd0;
	localparam act_code_t CARVE_PRESS   = 2'd1;
	localparam act_code_t CARVE_RELEASE = 2'd2;

	typedef struct packed {
		logic [DZ_W-1:0]   dead_zone;
		logic [WIN_W-1:0]  carve_window_ms;
		logic [GAIN_W-1:0] aim_gain;
	} cfg_t;

	typedef struct packed {
		logic             touched;
		logic             release_seen;
		logic [KEY_N-1:0] held;
		logic [1:0]       locks;
	} ctrl_t;

	typedef struct packed {
		act_code_t left;
		act_code_t right;
		act_code_t up;
		act_code_t down;
		act_code_t carve;
	} act_t;

	function automatic act_code_t act_code(input logic press, input logic rel);
		act_code_t c;
		case ({rel, press})
			2'b01:   c = ACT_PRESS;
			2'b10:   c = ACT_RELEASE;
			2'b11:   c = ACT_BOTH;
			default: c = ACT_NONE;
		endcase
		return c;
	endfunction

endpackage

### hw/rtl/tsdk_cfg.sv
module tsdk_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tsdk_pkg::PADDR_W-1:0]  paddr,
	input  logic [tsdk_pkg::PDATA_W-1:0]  pwdata,
	output logic [tsdk_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output tsdk_pkg::cfg_t                cfg
);
	import tsdk_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = paddr[PADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dead_zone       <= DEAD_ZONE_RST;
			cfg_q.carve_window_ms <= CARVE_WIN_RST;
			cfg_q.aim_gain        <= AIM_GAIN_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_DEAD_ZONE: cfg_q.dead_zone       <= pwdata[DZ_W-1:0];
				REG_CARVE_WIN: cfg_q.carve_window_ms <= pwdata[WIN_W-1:0];
				REG_AIM_GAIN:  cfg_q.aim_gain        <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DEAD_ZONE: prdata = PDATA_W'(cfg_q.dead_zone);
			REG_CARVE_WIN: prdata = PDATA_W'(cfg_q.carve_window_ms);
			REG_AIM_GAIN:  prdata = PDATA_W'(cfg_q.aim_gain);
			default:       prdata = '0;
		endcase
	end

endmodule

### hw/rtl/tsdk_step.sv
module tsdk_step #(
	parameter int AXIS_BITS = tsdk_pkg::AXIS_BITS_DEFAULT,
	parameter int TIME_BITS = tsdk_pkg::TIME_BITS_DEFAULT
) (
	input  tsdk_pkg::cfg_t                              cfg,
	input  logic signed [AXIS_BITS-1:0]                 pos_x,
	input  logic signed [AXIS_BITS-1:0]                 pos_y,
	input  logic                                        menu_mode,
	input  logic [TIME_BITS-1:0]                        now_ms,
	input  logic [tsdk_pkg::DELTA_W-1:0]                delta_ms,
	input  tsdk_pkg::ctrl_t                             ctrl,
	input  logic signed [tsdk_pkg::REF_X_W-1:0]         ref_x,
	input  logic signed [AXIS_BITS-1:0]                 ref_y,
	input  logic signed [tsdk_pkg::AIM_W-1:0]           aim,
	input  logic [TIME_BITS-1:0]                        stamp,
	output tsdk_pkg::ctrl_t                             ctrl_nxt,
	output logic signed [tsdk_pkg::REF_X_W-1:0]         ref_x_nxt,
	output logic signed [AXIS_BITS-1:0]                 ref_y_nxt,
	output logic signed [tsdk_pkg::AIM_W-1:0]           aim_nxt,
	output logic [TIME_BITS-1:0]                        stamp_nxt,
	output tsdk_pkg::act_t                              act
);
	import tsdk_pkg::*;

	logic                            touched;
	logic [TIME_BITS-1:0]            elapsed;
	logic                            in_window;
	logic signed [XD_W-1:0]          pxe, dze, dz3e, dl, dr;
	logic signed [REF_X_W-1:0]       rx;
	logic signed [AXIS_BITS-1:0]     ry;
	logic signed [AIM_W-1:0]         aim0, aim_c, aim_d, aim_u;
	logic signed [AXIS_BITS:0]       dy;
	logic [AXIS_BITS-1:0]            mag;
	logic [XD_W-1:0]                 mag2, dz5;
	logic                            step_y;
	logic [AXIS_BITS+GAIN_W-1:0]     prod;
	logic [AXIS_BITS-1:0]            qmag;
	logic signed [AIM_W:0]           aim_add, aim_sum, de, a_sub, a_add;
	logic [KEY_N-1:0]                held, press, rel;
	logic [1:0]                      locks;
	act_code_t                       carve;

	assign touched   = (pos_x != '0) || (pos_y != '0);
	assign elapsed   = now_ms - stamp;
	assign in_window = (TIME_BITS+1)'(elapsed) < (TIME_BITS+1)'(cfg.carve_window_ms);
	assign pxe       = XD_W'(pos_x);
	assign dze       = signed'(XD_W'(cfg.dead_zone));
	assign dz3e      = dze + (dze <<< 1);
	assign dz5       = XD_W'({cfg.dead_zone, 2'b00}) + XD_W'(cfg.dead_zone);
	assign de        = signed'((AIM_W+1)'(delta_ms));

	always_comb begin
		held     = ctrl.held;
		locks    = ctrl.locks;
		press    = '0;
		rel      = '0;
		carve    = CARVE_NONE;
		ctrl_nxt = ctrl;
		rx       = ref_x;
		ry       = ref_y;
		aim0     = aim;
		aim_nxt  = aim;
		stamp_nxt = stamp;
		dl = '0; dr = '0; dy = '0; mag = '0; mag2 = '0; step_y = 1'b0;
		prod = '0; qmag = '0; aim_add = '0; aim_sum = '0;
		aim_c = '0; aim_d = '0; aim_u = '0; a_sub = '0; a_add = '0;

		// A held carve key lasts one poll only
		if (held[KEY_CARVE]) begin
			held[KEY_CARVE] = 1'b0;
			carve = CARVE_RELEASE;
		end

		if (!touched) begin
			if (ctrl.touched) begin
				ctrl_nxt.touched      = 1'b0;
				ctrl_nxt.release_seen = 1'b1;
				stamp_nxt             = now_ms;
				held[KEY_DOWN:KEY_LEFT] = '0;
				locks                 = '0;
				rel[KEY_DOWN:KEY_LEFT] = '1;
			end
		end else begin
			if (!ctrl.touched) begin
				ctrl_nxt.touched = 1'b1;
				rx   = REF_X_W'(pxe);
				ry   = pos_y;
				aim0 = '0;
				if (ctrl.release_seen && in_window) begin
					held[KEY_CARVE] = 1'b1;
					carve = CARVE_PRESS;
				end
			end

			// Left, with the reference trailing the stick
			dl = pxe - XD_W'(rx);
			if (dl < -dze) begin
				if (!held[KEY_LEFT]) begin
					held[KEY_LEFT]  = 1'b1;
					locks[LOCK_H]   = 1'b1;
					press[KEY_LEFT] = 1'b1;
				end
				if (dl < -dz3e)
					rx = menu_mode ? REF_X_W'(pxe) : REF_X_W'(pxe + dz3e);
			end else if (held[KEY_LEFT]) begin
				held[KEY_LEFT] = 1'b0;
				rel[KEY_LEFT]  = 1'b1;
			end

			// Right
			dr = pxe - XD_W'(rx);
			if (dr > dze) begin
				if (!held[KEY_RIGHT]) begin
					held[KEY_RIGHT]  = 1'b1;
					locks[LOCK_H]    = 1'b1;
					press[KEY_RIGHT] = 1'b1;
				end
				if (dr > dz3e)
					rx = menu_mode ? REF_X_W'(pxe) : REF_X_W'(pxe - dz3e);
			end else if (held[KEY_RIGHT]) begin
				held[KEY_RIGHT] = 1'b0;
				rel[KEY_RIGHT]  = 1'b1;
			end

			if (menu_mode) begin
				if (locks[LOCK_H])
					ry = pos_y;
				if (locks[LOCK_V])
					rx = REF_X_W'(pxe);
			end

			// Y motion: one step in menu mode, scaled by the gain otherwise
			dy   = (AXIS_BITS+1)'(pos_y) - (AXIS_BITS+1)'(ry);
			mag  = dy[AXIS_BITS] ? AXIS_BITS'(-dy) : AXIS_BITS'(dy);
			mag2 = XD_W'({mag, 1'b0});
			step_y = mag2 > dz5;
			prod = (AXIS_BITS+GAIN_W)'(mag) * (AXIS_BITS+GAIN_W)'(cfg.aim_gain);
			qmag = prod[AXIS_BITS+GAIN_W-1:GAIN_W];
			if (menu_mode) begin
				if (step_y) begin
					aim_add = dy[AXIS_BITS] ? -(AIM_W+1)'(1) : (AIM_W+1)'(1);
					ry = pos_y;
					locks[LOCK_V] = 1'b1;
				end
			end else begin
				aim_add = dy[AXIS_BITS] ? -signed'((AIM_W+1)'(qmag))
				                        : signed'((AIM_W+1)'(qmag));
				ry = pos_y;
			end
			aim_sum = (AIM_W+1)'(aim0) + aim_add;
			if (aim_sum > (AIM_W+1)'(AIM_MAX))
				aim_c = AIM_MAX;
			else if (aim_sum < (AIM_W+1)'(AIM_MIN))
				aim_c = AIM_MIN;
			else
				aim_c = AIM_W'(aim_sum);

			// Decay toward zero; down drives positive, up negative
			a_sub = (AIM_W+1)'(aim_c) - de;
			a_add = (AIM_W+1)'(aim_c) + de;
			aim_d = aim_c;
			if (aim_c > 0) begin
				if (!held[KEY_DOWN]) begin
					held[KEY_DOWN]  = 1'b1;
					press[KEY_DOWN] = 1'b1;
				end
				aim_d = (a_sub < 0) ? '0 : AIM_W'(a_sub);
			end
			if (aim_d <= 0 && held[KEY_DOWN]) begin
				held[KEY_DOWN] = 1'b0;
				rel[KEY_DOWN]  = 1'b1;
			end
			aim_u = aim_d;
			if (aim_d < 0) begin
				if (!held[KEY_UP]) begin
					held[KEY_UP]  = 1'b1;
					press[KEY_UP] = 1'b1;
				end
				aim_u = (a_add > 0) ? '0 : AIM_W'(a_add);
			end
			if (aim_u >= 0 && held[KEY_UP]) begin
				held[KEY_UP] = 1'b0;
				rel[KEY_UP]  = 1'b1;
			end
			aim_nxt = aim_u;
		end

		ctrl_nxt.held  = held;
		ctrl_nxt.locks = locks;
		ref_x_nxt      = rx;
		ref_y_nxt      = ry;

		act.left  = act_code(press[KEY_LEFT],  rel[KEY_LEFT]);
		act.right = act_code(press[KEY_RIGHT], rel[KEY_RIGHT]);
		act.up    = act_code(press[KEY_UP],    rel[KEY_UP]);
		act.down  = act_code(press[KEY_DOWN],  rel[KEY_DOWN]);
		act.carve = carve;
	end

endmodule

### hw/rtl/touch_stick_to_dpad_keys_unit.sv
// Touch stick to direction keys.
// Poll channel: pos_x, pos_y, menu_mode, now_ms and delta_ms move as one
// transaction when poll_valid is high and poll_stall is low. Key channel:
// one transaction of five action codes (left, right, up, down, carve) per
// poll, taken when key_valid is high and key_stall is low.
// A taken poll is loaded into the input register, and its keys are
// registered in the result register, which drives the key channel.
// Throughput: one poll per cycle while no result waits under key_stall.
// The whole step (dead zone compares, the 16x16 aim gain multiply, aim
// clamp and decay) is combinational between the input register and the
// key register, with the stick state updated at the same edge the result
// is registered.
// Stall: while key_stall holds a pending result, the input register holds
// its poll and poll_stall rises; a new poll is still taken while a result
// waits, as long as the input register is free.
// Reset (arst_n low): both registers empty, all keys released, references
// and aim counter zero, no release seen, configuration at its defaults.
// Configuration: APB, dead_zone at 0x0, carve_window_ms at 0x4, aim_gain at
// 0x8; write only while no poll is in flight.
`include "touch_stick_to_dpad_keys_unit_assert.svh"

module touch_stick_to_dpad_keys_unit #(
	parameter int AXIS_BITS = tsdk_pkg::AXIS_BITS_DEFAULT,
	parameter int TIME_BITS = tsdk_pkg::TIME_BITS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// APB configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tsdk_pkg::PADDR_W-1:0]      paddr,
	input  logic [tsdk_pkg::PDATA_W-1:0]      pwdata,
	output logic [tsdk_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready,
	// Poll channel
	input  logic                              poll_valid,
	output logic                              poll_stall,
	input  logic signed [AXIS_BITS-1:0]       pos_x,
	input  logic signed [AXIS_BITS-1:0]       pos_y,
	input  logic                              menu_mode,
	input  logic [TIME_BITS-1:0]              now_ms,
	input  logic [tsdk_pkg::DELTA_W-1:0]      delta_ms,
	// Key channel
	output logic                              key_valid,
	input  logic                              key_stall,
	output logic [tsdk_pkg::ACT_W-1:0]        left_action,
	output logic [tsdk_pkg::ACT_W-1:0]        right_action,
	output logic [tsdk_pkg::ACT_W-1:0]        up_action,
	output logic [tsdk_pkg::ACT_W-1:0]        down_action,
	output logic [tsdk_pkg::ACT_W-1:0]        carve_action
);
	import tsdk_pkg::*;

	cfg_t cfg;

	// Input register
	logic                          valid_s1;
	logic signed [AXIS_BITS-1:0]   pos_x_s1, pos_y_s1;
	logic                          menu_s1;
	logic [TIME_BITS-1:0]          now_s1;
	logic [DELTA_W-1:0]            delta_s1;

	// Result register
	logic                          valid_s2;
	act_t                          act_s2;

	// Stick state
	ctrl_t                         ctrl_q, ctrl_nxt;
	logic signed [REF_X_W-1:0]     ref_x_q, ref_x_nxt;
	logic signed [AXIS_BITS-1:0]   ref_y_q, ref_y_nxt;
	logic signed [AIM_W-1:0]       aim_q, aim_nxt;
	logic [TIME_BITS-1:0]          stamp_q, stamp_nxt;
	act_t                          step_act;

	logic                          adv_s1;
	logic                          poll_fire;
	logic                          step_fire;

	// The input register moves on whenever the result register is free or
	// its transaction is being taken.
	assign adv_s1     = !valid_s2 || !key_stall;
	assign poll_stall = valid_s1 && !adv_s1;
	assign poll_fire  = poll_valid && !poll_stall;
	assign step_fire  = valid_s1 && adv_s1;

	tsdk_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tsdk_step #(
		.AXIS_BITS (AXIS_BITS),
		.TIME_BITS (TIME_BITS)
	) u_step (
		.cfg       (cfg),
		.pos_x     (pos_x_s1),
		.pos_y     (pos_y_s1),
		.menu_mode (menu_s1),
		.now_ms    (now_s1),
		.delta_ms  (delta_s1),
		.ctrl      (ctrl_q),
		.ref_x     (ref_x_q),
		.ref_y     (ref_y_q),
		.aim       (aim_q),
		.stamp     (stamp_q),
		.ctrl_nxt  (ctrl_nxt),
		.ref_x_nxt (ref_x_nxt),
		.ref_y_nxt (ref_y_nxt),
		.aim_nxt   (aim_nxt),
		.stamp_nxt (stamp_nxt),
		.act       (step_act)
	);

	// Input register control: load on a taken poll, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv_s1) begin
			valid_s1 <= poll_valid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (poll_fire) begin
			pos_x_s1 <= pos_x;
			pos_y_s1 <= pos_y;
			menu_s1  <= menu_mode;
			now_s1   <= now_ms;
			delta_s1 <= delta_ms;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (step_fire) begin
			act_s2 <= step_act;
		end
	end

	// Stick state advances with each poll as its result is registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q  <= '0;
			ref_x_q <= '0;
			ref_y_q <= '0;
			aim_q   <= '0;
			stamp_q <= '0;
		end else if (step_fire) begin
			ctrl_q  <= ctrl_nxt;
			ref_x_q <= ref_x_nxt;
			ref_y_q <= ref_y_nxt;
			aim_q   <= aim_nxt;
			stamp_q <= stamp_nxt;
		end
	end

	assign key_valid    = valid_s2;
	assign left_action  = act_s2.left;
	assign right_action = act_s2.right;
	assign up_action    = act_s2.up;
	assign down_action  = act_s2.down;
	assign carve_action = act_s2.carve;

	// A stalled poll stays put in the input register
	`TSDK_ASSERT_NXT(a_s1_hold, clk, arst_n, valid_s1 && !adv_s1, valid_s1 && $stable(pos_x_s1) && $stable(now_s1), "stalled poll lost or changed")
	// The aim counter never leaves its saturation range
	`TSDK_ASSERT_IMP(a_aim_range, clk, arst_n, 1'b1, (aim_q <= AIM_MAX) && (aim_q >= AIM_MIN), "aim counter out of range")
	// Menu axis locks only live while the stick is touched
	`TSDK_ASSERT_IMP(a_locks_idle, clk, arst_n, !ctrl_q.touched, ctrl_q.locks == '0, "axis lock set while untouched")
	// A carve press leaves the carve key held for exactly the next poll
	`TSDK_ASSERT_NXT(a_carve_held, clk, arst_n, step_fire && (step_act.carve == CARVE_PRESS), ctrl_q.held[KEY_CARVE], "carve press not held")

endmodule
